[rtl/core/uart_8250_register_model_assert.svh]
// assertion macros for the 8250 register model
`ifndef UART_8250_REGISTER_MODEL_ASSERT_SVH
`define UART_8250_REGISTER_MODEL_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define U8250_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent that must hold in the cycle after the antecedent
`define U8250_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define U8250_ASSERT_ALWAYS(lbl, prop, msg)
`define U8250_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/u8250_pkg.sv]
package u8250_pkg;

    // kind of input word
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RX    = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // register offsets
    typedef enum logic [2:0] {
        OFF_DATA = 3'd0,
        OFF_IER  = 3'd1,
        OFF_IIR  = 3'd2,
        OFF_LCR  = 3'd3,
        OFF_MCR  = 3'd4,
        OFF_LSR  = 3'd5,
        OFF_MSR  = 3'd6
    } offset_t;

    localparam int unsigned DLAB_POS  = 7;
    localparam logic [7:0]  LSR_BASE  = 8'h60;
    localparam logic [7:0]  MSR_VALUE = 8'hb0;

    // pending interrupt bit positions
    localparam int unsigned INT_RX_POS   = 0;
    localparam int unsigned INT_THRE_POS = 1;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

endpackage

[rtl/core/uart_8250_register_model.sv]
// channel | dir | tdata fields (lsb up)                                        | tuser
// s_*     | in  | reg_offset[2:0] write_data[10:3] line_byte[18:11], zero pad   | action[1:0]
// m_*     | out | read_data[7:0] tx_valid[8] tx_byte[16:9] rx_accepted[17]
//         |     | irq[18], zero pad                                            | -
//
// one word per clock sustained while m_tready is held high; a word is captured in the
// input register s1 and then in the output register before it appears on m_*
// the register file is updated as a word moves from the input register to the
// output register, so each word sees the state left by the one before it
// a stalled output holds its word while one more input word waits in s1
// rst_n clears the valid flags and the register file and leaves both stages empty
module uart_8250_register_model
    import u8250_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // reg_offset, write_data, line_byte
    input  logic [IN_USER_W-1:0]  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // read_data, tx_valid, tx_byte, rx_accepted, irq
);

    // input stage
    logic          s1_valid_reg;
    action_t       s1_action_reg;
    logic [2:0]    s1_offset_reg;
    logic [7:0]    s1_wdata_reg;
    logic [7:0]    s1_lbyte_reg;

    // output stage
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;

    // register file
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlh_reg, dlh_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [1:0] pend_reg, pend_next;
    logic       cur_reg, cur_next;
    logic       rx_full_reg, rx_full_next;
    logic [7:0] rx_hold_reg, rx_hold_next;

    logic advance;

    // handshake: the word in s1 moves on whenever the output slot frees
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // register access and interrupt update for the word in s1
    always_comb
    begin
        logic       dlab;
        logic [7:0] rdata;
        logic       txv;
        logic [7:0] txb;
        logic       acc;
        logic [1:0] p;

        dll_next     = dll_reg;
        dlh_next     = dlh_reg;
        lcr_next     = lcr_reg;
        ier_next     = ier_reg;
        mcr_next     = mcr_reg;
        cur_next     = cur_reg;
        rx_full_next = rx_full_reg;
        rx_hold_next = rx_hold_reg;
        dlab         = lcr_reg[DLAB_POS];
        rdata        = 8'd0;
        txv          = 1'b0;
        txb          = 8'd0;
        acc          = 1'b0;
        p            = pend_reg;

        unique case (s1_action_reg)
            ACT_READ:
            begin
                unique case (offset_t'(s1_offset_reg))
                    OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            rdata = dll_reg;
                        end
                        else if (rx_full_reg)
                        begin
                            rdata        = rx_hold_reg;
                            rx_full_next = 1'b0;
                        end
                    end
                    OFF_IER: rdata = dlab ? dlh_reg : ier_reg;
                    OFF_IIR:
                    begin
                        rdata = {6'd0, cur_reg, (pend_reg == 2'd0)};
                        // reading iir acknowledges transmit empty when that is the reported interrupt
                        if (cur_reg)
                        begin
                            p[INT_THRE_POS] = 1'b0;
                        end
                    end
                    OFF_LCR: rdata = lcr_reg;
                    OFF_MCR: rdata = mcr_reg;
                    OFF_LSR: rdata = LSR_BASE | {7'd0, rx_full_reg};
                    OFF_MSR: rdata = MSR_VALUE;
                    default: rdata = 8'd0;
                endcase
            end
            ACT_WRITE:
            begin
                unique case (offset_t'(s1_offset_reg))
                    OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = s1_wdata_reg;
                        end
                        else
                        begin
                            txv              = 1'b1;
                            txb              = s1_wdata_reg;
                            p[INT_THRE_POS]  = 1'b1;
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                        begin
                            dlh_next = s1_wdata_reg;
                        end
                        else
                        begin
                            ier_next = s1_wdata_reg;
                        end
                    end
                    OFF_LCR: lcr_next = s1_wdata_reg;
                    OFF_MCR: mcr_next = s1_wdata_reg;
                    default: ;
                endcase
            end
            ACT_RX:
            begin
                // a full holding register drops the new byte
                if (!rx_full_reg)
                begin
                    rx_hold_next = s1_lbyte_reg;
                    rx_full_next = 1'b1;
                    acc          = 1'b1;
                end
            end
            default: ;
        endcase

        // interrupt recompute, skipped for the no-op kind
        if (s1_action_reg != ACT_NONE)
        begin
            p[INT_RX_POS] = rx_full_next;
            p             = p & ier_next[1:0];
            if (p != 2'd0)
            begin
                cur_next = p[INT_THRE_POS];
            end
        end

        pend_next   = p;
        m_data_next = {5'd0, (p != 2'd0), acc, txb, txv, rdata};
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_action_reg <= action_t'(s_tuser);
            s1_offset_reg <= s_tdata[2:0];
            s1_wdata_reg  <= s_tdata[10:3];
            s1_lbyte_reg  <= s_tdata[18:11];
        end
    end

    // output register and register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            dll_reg     <= 8'd0;
            dlh_reg     <= 8'd0;
            lcr_reg     <= 8'd0;
            ier_reg     <= 8'd0;
            mcr_reg     <= 8'd0;
            pend_reg    <= 2'd0;
            cur_reg     <= 1'b0;
            rx_full_reg <= 1'b0;
            rx_hold_reg <= 8'd0;
        end
        else
        begin
            if (advance)
            begin
                m_valid_reg <= 1'b1;
                dll_reg     <= dll_next;
                dlh_reg     <= dlh_next;
                lcr_reg     <= lcr_next;
                ier_reg     <= ier_next;
                mcr_reg     <= mcr_next;
                pend_reg    <= pend_next;
                cur_reg     <= cur_next;
                rx_full_reg <= rx_full_next;
                rx_hold_reg <= rx_hold_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // checks
`include "uart_8250_register_model_assert.svh"

    `U8250_ASSERT_ALWAYS(a_irq_matches_state, !m_valid_reg || (m_data_reg[18] == (pend_reg != 2'd0)), "irq in output word disagrees with pending state")
    `U8250_ASSERT_ALWAYS(a_pending_masked, (pend_reg & ~ier_reg[1:0]) == 2'd0, "pending interrupt not enabled")
    `U8250_ASSERT_NEXT(a_full_keeps_byte, advance && (s1_action_reg == ACT_RX) && rx_full_reg, $stable(rx_hold_reg) && rx_full_reg, "held byte overwritten while full")

endmodule

[tb/tb_uart_8250_register_model.sv]
`timescale 1ns / 1ps

import u8250_pkg::*;

// one response word, packed as on m_tdata, members listed from the highest bit down
typedef struct packed {
    logic       irq;
    logic       rx_accepted;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
} uart_resp_t;

// shadow register file plus the queue of responses still to come
class uart_reg_scoreboard;
    logic [7:0] dll;
    logic [7:0] dlh;
    logic [7:0] lcr;
    logic [7:0] ier;
    logic [7:0] mcr;
    logic [1:0] pend;
    logic       cur_int;
    logic       rx_full;
    logic [7:0] rx_hold;
    uart_resp_t awaited_resp[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
        dll = '0;
        dlh = '0;
        lcr = '0;
        ier = '0;
        mcr = '0;
        pend = '0;
        cur_int = 1'b0;
        rx_full = 1'b0;
        rx_hold = '0;
        mismatches = 0;
        checked = 0;
    endfunction

    task report_mismatch(input string what, input int unsigned got, input int unsigned want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // receive-ready follows the holding flag, then enable mask, then priority
    function void update_ints();
        pend[INT_RX_POS] = rx_full;
        pend = pend & ier[1:0];
        if (pend != 2'b00)
            cur_int = pend[INT_THRE_POS];
    endfunction

    function uart_resp_t reg_access(input action_t act, input logic [2:0] off,
                                    input logic [7:0] wd, input logic [7:0] lb);
        uart_resp_t r;
        logic       dlab;
        r = '0;
        dlab = lcr[DLAB_POS];
        case (act)
            ACT_READ:
            begin
                case (off)
                    OFF_DATA:
                    begin
                        if (dlab)
                            r.read_data = dll;
                        else if (rx_full)
                        begin
                            r.read_data = rx_hold;
                            rx_full = 1'b0;
                        end
                    end
                    OFF_IER: r.read_data = dlab ? dlh : ier;
                    OFF_IIR:
                    begin
                        r.read_data = {6'b0, cur_int, pend == 2'b00};
                        // reading iir drops transmit-empty when that is the reported interrupt
                        if (cur_int)
                            pend[INT_THRE_POS] = 1'b0;
                    end
                    OFF_LCR: r.read_data = lcr;
                    OFF_MCR: r.read_data = mcr;
                    OFF_LSR: r.read_data = LSR_BASE | {7'b0, rx_full};
                    OFF_MSR: r.read_data = MSR_VALUE;
                    default: r.read_data = '0;
                endcase
                update_ints();
            end
            ACT_WRITE:
            begin
                case (off)
                    OFF_DATA:
                    begin
                        if (dlab)
                            dll = wd;
                        else
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = wd;
                            pend[INT_THRE_POS] = 1'b1;
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                            dlh = wd;
                        else
                            ier = wd;
                    end
                    OFF_LCR: lcr = wd;
                    OFF_MCR: mcr = wd;
                    default: ;
                endcase
                update_ints();
            end
            ACT_RX:
            begin
                // a byte arriving while full is dropped
                if (!rx_full)
                begin
                    rx_hold = lb;
                    rx_full = 1'b1;
                    r.rx_accepted = 1'b1;
                end
                update_ints();
            end
            default: ;
        endcase
        r.irq = (pend != 2'b00);
        return r;
    endfunction

    function void note_word(input action_t act, input logic [2:0] off,
                            input logic [7:0] wd, input logic [7:0] lb);
        awaited_resp.push_back(reg_access(act, off, wd, lb));
    endfunction

    task check_response(input logic [23:0] word);
        uart_resp_t got;
        uart_resp_t want;
        got = uart_resp_t'(word[18:0]);
        if (awaited_resp.size() == 0)
        begin
            report_mismatch("unexpected response word", word, 0);
        end
        else
        begin
            want = awaited_resp.pop_front();
            checked++;
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
            if (got.tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
            if (got.rx_accepted !== want.rx_accepted)
                report_mismatch("rx_accepted", got.rx_accepted, want.rx_accepted);
            if (got.irq !== want.irq)
                report_mismatch("irq", got.irq, want.irq);
        end
    endtask
endclass

module tb_uart_8250_register_model;

    localparam logic [2:0]  OFF_UNUSED = 3'd7;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned PHASE_WORDS = 630;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int unsigned send_idle = 33;
    int unsigned recv_idle = 63;
    int unsigned words_sent = 0;
    int unsigned idle_cycles = 0;

    uart_reg_scoreboard sb = new();

    uart_8250_register_model u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // response check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata);
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("** uart_8250_register_model: FAILED **");
                $finish;
            end
        end
    end

    // offer one word, with random gaps before it, and wait for acceptance
    task automatic send_word(input action_t act, input logic [2:0] off,
                             input logic [7:0] wd, input logic [7:0] lb);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {5'b0, lb, wd, off};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(act, off, wd, lb);
        words_sent++;
    endtask

    // one random word, biased toward the registers that matter
    task automatic random_word();
        int unsigned pick;
        logic [2:0]  off;
        logic [7:0]  wd;
        pick = $urandom_range(99);
        off = 3'($urandom_range(7));
        wd = 8'($urandom);
        if (pick < 40)
        begin
            send_word(ACT_READ, off, wd, 8'($urandom));
        end
        else if (pick < 75)
        begin
            if ($urandom_range(1) == 0)
                off = ($urandom_range(2) == 0) ? OFF_DATA :
                      ($urandom_range(1) == 0) ? OFF_IER : OFF_LCR;
            // keep the divisor latch mostly closed
            if (off == OFF_LCR)
                wd[DLAB_POS] = ($urandom_range(99) < 30);
            send_word(ACT_WRITE, off, wd, 8'($urandom));
        end
        else if (pick < 95)
        begin
            send_word(ACT_RX, off, wd, 8'($urandom));
        end
        else
        begin
            send_word(ACT_NONE, off, wd, 8'($urandom));
        end
    endtask

    // interrupt round trip: enable, transmit, status, receive, status, then drain or line status read
    task automatic irq_round();
        send_word(ACT_WRITE, OFF_LCR, {1'b0, 7'($urandom)}, 8'($urandom));
        send_word(ACT_WRITE, OFF_IER, 8'($urandom), 8'($urandom));
        send_word(ACT_WRITE, OFF_DATA, 8'($urandom), 8'($urandom));
        send_word(ACT_READ, OFF_IIR, 8'($urandom), 8'($urandom));
        send_word(ACT_RX, 3'($urandom), 8'($urandom), 8'($urandom));
        send_word(ACT_READ, OFF_IIR, 8'($urandom), 8'($urandom));
        send_word(ACT_READ, ($urandom_range(1) == 0) ? OFF_DATA : OFF_LSR,
                  8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset values, divisor latch, interrupts, full receiver, other registers
        send_word(ACT_READ, OFF_DATA, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_IIR, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_UNUSED, 8'h00, 8'h00);
        send_word(ACT_NONE, OFF_DATA, 8'hff, 8'hff);
        send_word(ACT_WRITE, OFF_LCR, 8'h80, 8'h00);
        send_word(ACT_WRITE, OFF_DATA, 8'hff, 8'h00);
        send_word(ACT_WRITE, OFF_IER, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_DATA, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_IER, 8'h00, 8'h00);
        send_word(ACT_WRITE, OFF_LCR, 8'h03, 8'h00);
        send_word(ACT_WRITE, OFF_IER, 8'hff, 8'h00);
        send_word(ACT_WRITE, OFF_DATA, 8'h00, 8'h00);
        send_word(ACT_NONE, OFF_UNUSED, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_IIR, 8'h00, 8'h00);
        send_word(ACT_RX, OFF_DATA, 8'h00, 8'hff);
        send_word(ACT_RX, OFF_DATA, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_LSR, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_DATA, 8'h00, 8'h00);
        send_word(ACT_READ, OFF_DATA, 8'h00, 8'h00);
        send_word(ACT_WRITE, OFF_IIR, 8'hff, 8'h00);
        send_word(ACT_WRITE, OFF_LSR, 8'hff, 8'h00);
        send_word(ACT_WRITE, OFF_MSR, 8'hff, 8'h00);
        send_word(ACT_WRITE, OFF_UNUSED, 8'hff, 8'h00);
        send_word(ACT_READ, OFF_MSR, 8'h00, 8'h00);
        send_word(ACT_WRITE, OFF_MCR, 8'hff, 8'h00);
        send_word(ACT_READ, OFF_MCR, 8'h00, 8'h00);

        // random: three back-pressure phases
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 33;
                    recv_idle = 63;
                end
                1:
                begin
                    send_idle = 63;
                    recv_idle = 33;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                if ($urandom_range(99) < 20)
                    irq_round();
                else
                    random_word();
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then let any stray word show up
        while (sb.awaited_resp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d words over three back-pressure phases, %0d responses checked",
                 words_sent, sb.checked);
        if (sb.mismatches == 0 && sb.awaited_resp.size() == 0)
            $display("** uart_8250_register_model: PASSED **");
        else
            $display("** uart_8250_register_model: FAILED **");
        $finish;
    end

endmodule
